// ----- src/ir_remote_pulse_decoder_defines.svh -----
// assertion helpers for the ir remote pulse decoder
`ifndef IR_REMOTE_PULSE_DECODER_DEFINES_SVH
`define IR_REMOTE_PULSE_DECODER_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define IRPD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("irpd check failed");

// next-cycle implication, checked on every rising edge outside reset
`define IRPD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("irpd check failed");

`endif

// ----- src/irpd_pkg.sv -----
package irpd_pkg;

    // fixed field widths
    localparam int TICK_W = 16;
    localparam int CODE_W = 32;
    localparam int CFG_W  = 16;
    localparam int ADDR_W = 4;

    // fixed timing windows in ticks
    localparam logic [TICK_W-1:0] HEADER_GAP_MIN = 16'd3870;
    localparam logic [TICK_W-1:0] HEADER_GAP_MAX = 16'd9460;
    localparam logic [TICK_W-1:0] SPACE_MIN      = 16'd800;
    localparam logic [TICK_W-1:0] SPACE_MAX      = 16'd3400;

    // bits in one full code and the counter that tracks them
    localparam int CODE_BITS = 32;
    localparam int CNT_W     = $clog2(CODE_BITS + 1);
    localparam logic [CNT_W-1:0] CODE_BITS_CNT = CNT_W'(CODE_BITS);

    // frame phase codes
    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_GAP       = 3'd1;
    localparam logic [2:0] PH_RPT_MARK  = 3'd2;
    localparam logic [2:0] PH_LEAD_MARK = 3'd3;
    localparam logic [2:0] PH_SPACE     = 3'd4;
    localparam logic [2:0] PH_MARK      = 3'd5;

    // register indexes
    localparam logic [ADDR_W-1:0] REG_START_MIN      = 4'd0;
    localparam logic [ADDR_W-1:0] REG_START_MAX      = 4'd1;
    localparam logic [ADDR_W-1:0] REG_REPEAT_GAP_MAX = 4'd2;
    localparam logic [ADDR_W-1:0] REG_CODE_GAP_MIN   = 4'd3;
    localparam logic [ADDR_W-1:0] REG_MARK_MIN       = 4'd4;
    localparam logic [ADDR_W-1:0] REG_MARK_MAX       = 4'd5;
    localparam logic [ADDR_W-1:0] REG_ZERO_SPACE_MAX = 4'd6;
    localparam logic [ADDR_W-1:0] REG_ONE_SPACE_MIN  = 4'd7;

    typedef struct packed {
        logic [CFG_W-1:0] start_min;
        logic [CFG_W-1:0] start_max;
        logic [CFG_W-1:0] repeat_gap_max;
        logic [CFG_W-1:0] code_gap_min;
        logic [CFG_W-1:0] mark_min;
        logic [CFG_W-1:0] mark_max;
        logic [CFG_W-1:0] zero_space_max;
        logic [CFG_W-1:0] one_space_min;
    } irpd_cfg_t;

    localparam irpd_cfg_t CFG_RESET = '{
        start_min:      16'd15480,
        start_max:      16'd18920,
        repeat_gap_max: 16'd4730,
        code_gap_min:   16'd7740,
        mark_min:       16'd1000,
        mark_max:       16'd1300,
        zero_space_max: 16'd1200,
        one_space_min:  16'd2900
    };

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code_word;
        logic              is_repeat;
    } irpd_result_t;

    typedef struct packed {
        logic [2:0]        phase;
        logic [CNT_W-1:0]  bit_count;
        logic [CODE_W-1:0] last_code;
    } irpd_status_t;

endpackage

// ----- src/irpd_cfg_regs.sv -----
module irpd_cfg_regs
    import irpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata,
    output irpd_cfg_t         cfg
);

    irpd_cfg_t cfg_reg;
    irpd_cfg_t cfg_next;

    // register write decode, indexes past the list are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_START_MIN:      cfg_next.start_min      = cfg_wdata;
                REG_START_MAX:      cfg_next.start_max      = cfg_wdata;
                REG_REPEAT_GAP_MAX: cfg_next.repeat_gap_max = cfg_wdata;
                REG_CODE_GAP_MIN:   cfg_next.code_gap_min   = cfg_wdata;
                REG_MARK_MIN:       cfg_next.mark_min       = cfg_wdata;
                REG_MARK_MAX:       cfg_next.mark_max       = cfg_wdata;
                REG_ZERO_SPACE_MAX: cfg_next.zero_space_max = cfg_wdata;
                REG_ONE_SPACE_MIN:  cfg_next.one_space_min  = cfg_wdata;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/irpd_core.sv -----
module irpd_core
    import irpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  irpd_cfg_t         cfg,
    input  logic              fire,
    input  logic              pulse_level,
    input  logic [TICK_W-1:0] pulse_ticks,
    output irpd_result_t      result,
    output irpd_status_t      status
);

    logic [2:0]        phase_reg;
    logic [2:0]        phase_next;
    logic [CNT_W-1:0]  bit_count_reg;
    logic [CNT_W-1:0]  bit_count_next;
    logic [CODE_W-1:0] shift_word_reg;
    logic [CODE_W-1:0] shift_word_next;
    logic [CODE_W-1:0] last_code_reg;
    logic [CODE_W-1:0] last_code_next;

    logic mark_ok;
    logic gap_in_range;
    logic space_in_range;

    // window checks shared by the phases
    assign mark_ok        = !pulse_level && (pulse_ticks >= cfg.mark_min)
                            && (pulse_ticks <= cfg.mark_max);
    assign gap_in_range   = pulse_level && (pulse_ticks >= HEADER_GAP_MIN)
                            && (pulse_ticks <= HEADER_GAP_MAX);
    assign space_in_range = pulse_level && (pulse_ticks >= SPACE_MIN)
                            && (pulse_ticks <= SPACE_MAX);

    // frame decode, one pulse per fire; anything unexpected falls back to idle
    always_comb
    begin
        phase_next       = phase_reg;
        bit_count_next   = bit_count_reg;
        shift_word_next  = shift_word_reg;
        last_code_next   = last_code_reg;
        result.valid     = 1'b0;
        result.code_word = shift_word_reg;
        result.is_repeat = 1'b0;
        if (fire)
        begin
            phase_next = PH_IDLE;
            unique case (phase_reg)
                PH_GAP:
                begin
                    if (gap_in_range)
                    begin
                        if (pulse_ticks < cfg.repeat_gap_max)
                            phase_next = PH_RPT_MARK;
                        else if (pulse_ticks >= cfg.code_gap_min)
                            phase_next = PH_LEAD_MARK;
                    end
                end
                PH_RPT_MARK:
                begin
                    if (!pulse_level)
                    begin
                        result.valid     = 1'b1;
                        result.code_word = last_code_reg;
                        result.is_repeat = 1'b1;
                    end
                end
                PH_LEAD_MARK:
                begin
                    if (mark_ok)
                    begin
                        bit_count_next  = '0;
                        shift_word_next = '0;
                        phase_next      = PH_SPACE;
                    end
                end
                PH_SPACE:
                begin
                    if (space_in_range)
                    begin
                        if (pulse_ticks < cfg.zero_space_max)
                        begin
                            shift_word_next = {shift_word_reg[CODE_W-2:0], 1'b0};
                            bit_count_next  = bit_count_reg + CNT_W'(1);
                            phase_next      = PH_MARK;
                        end
                        else if (pulse_ticks > cfg.one_space_min)
                        begin
                            shift_word_next = {shift_word_reg[CODE_W-2:0], 1'b1};
                            bit_count_next  = bit_count_reg + CNT_W'(1);
                            phase_next      = PH_MARK;
                        end
                    end
                end
                PH_MARK:
                begin
                    if (mark_ok)
                    begin
                        if (bit_count_reg >= CODE_BITS_CNT)
                        begin
                            last_code_next   = shift_word_reg;
                            result.valid     = 1'b1;
                            result.code_word = shift_word_reg;
                            result.is_repeat = 1'b0;
                        end
                        else
                        begin
                            phase_next = PH_SPACE;
                        end
                    end
                end
                default:
                begin
                    if (!pulse_level && (pulse_ticks >= cfg.start_min)
                        && (pulse_ticks <= cfg.start_max))
                        phase_next = PH_GAP;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= '0;
            shift_word_reg <= '0;
            last_code_reg  <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            shift_word_reg <= shift_word_next;
            last_code_reg  <= last_code_next;
        end
    end

    assign status.phase     = phase_reg;
    assign status.bit_count = bit_count_reg;
    assign status.last_code = last_code_reg;

endmodule

// ----- src/ir_remote_pulse_decoder.sv -----
// ir remote pulse decoder
// Slave stream: one word per measured pulse, tdata = pulse duration in
// timer ticks, tuser = receiver level (0 carrier on, 1 high).
// Master stream: one word per completed frame, tdata = 32-bit code with the
// first received bit on top, tuser = 1 for a repeat frame carrying the last
// full code, 0 for a new code. Most pulses produce no output word.
// Config port: cfg_we with cfg_addr selects one of eight 16-bit timing
// thresholds; the user must write only while idle, the block does not check.
// Path: a pulse word waits in the input register until the result register
// is free, is then decoded, and its result is registered for the master side.
// Throughput: one pulse word per cycle while m_tready keeps up; the input
// and result registers hold a word each; frame state steps once per pulse.
// Stall: while a result waits on m_tready the next pulse still enters the
// input register; it is decoded once the result register is free, and
// s_tready drops only while both registers are occupied.
// Reset: decoder returns to idle awaiting a start pulse, last code and
// shift word clear, thresholds return to their defaults, both sides empty.
module ir_remote_pulse_decoder
    import irpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // pulse input
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [TICK_W-1:0] s_tdata,   // [15:0] pulse_ticks
    input  logic              s_tuser,   // [0] pulse_level
    // decoded output
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CODE_W-1:0] m_tdata,   // [31:0] code_word
    output logic              m_tuser,   // [0] is_repeat
    // config writes
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata
);

`include "ir_remote_pulse_decoder_defines.svh"

    irpd_cfg_t    cfg;
    irpd_result_t result;
    irpd_status_t status;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic              in_level_reg;
    logic [TICK_W-1:0] in_ticks_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CODE_W-1:0] out_code_reg;
    logic              out_repeat_reg;
    logic              fire;
    logic              s_accept;

    irpd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // decode the held pulse when the result register can take its outcome
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign s_accept = s_tvalid && s_tready;

    irpd_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .fire        (fire),
        .pulse_level (in_level_reg),
        .pulse_ticks (in_ticks_reg),
        .result      (result),
        .status      (status)
    );

    // input register control
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
    end

    // result register control
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
            out_valid_next = result.valid;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_level_reg <= s_tuser;
            in_ticks_reg <= s_tdata;
        end
        if (fire && result.valid)
        begin
            out_code_reg   <= result.code_word;
            out_repeat_reg <= result.is_repeat;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_code_reg;
    assign m_tuser  = out_repeat_reg;

    // checks
    `IRPD_ASSERT_IMP(a_no_fire_on_stall, out_valid_reg && !m_tready, !fire)
    `IRPD_ASSERT_IMP(a_bit_count_range, 1'b1, status.bit_count <= CODE_BITS_CNT)
    `IRPD_ASSERT_IMP(a_new_code_is_last, out_valid_reg && !out_repeat_reg,
        out_code_reg == status.last_code)
    `IRPD_ASSERT_NXT(a_idle_after_result, fire && result.valid,
        status.phase == PH_IDLE)

endmodule
